// ----- rtl/vmag_pkg.sv -----
// Shared types and the root-step function for the vector magnitude core.
`timescale 1ns / 1ps
`default_nettype none

package vmag_pkg;

    localparam int unsigned COMP_W  = 8;
    localparam int unsigned SUM_W   = 16;
    localparam int unsigned ROOT_W  = 9;
    localparam int unsigned MAG_W   = 8;
    localparam int unsigned TRIAL_W = 17;

    localparam logic METHOD_EXACT  = 1'b0;
    localparam logic METHOD_COARSE = 1'b1;

    // One item inside the root pipeline: partial remainder and doubled root.
    typedef struct packed {
        logic              vld;
        logic [SUM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } vmag_sq_t;

    // One restoring digit step at bit position k.
    function automatic vmag_sq_t vmag_root_step(vmag_sq_t d, int unsigned k);
        logic [TRIAL_W-1:0] trial;
        vmag_sq_t           r;
        r     = d;
        trial = ({{(TRIAL_W-ROOT_W){1'b0}}, d.root} + (TRIAL_W'(1) << k)) << k;
        if ({1'b0, d.rem} >= trial) begin
            r.rem  = d.rem - trial[SUM_W-1:0];
            r.root = d.root | (ROOT_W'(2) << k);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/vector_magnitude_int_sqrt_core.sv -----
// Top level of the integer vector magnitude core.
// Computes the integer length of a vector of two signed bytes.
// Input stream: s_tdata carries comp_x (bits 7:0) and comp_y (bits 15:8);
// a transfer happens when s_tvalid and s_tready are both high.
// Output stream: m_tdata carries the 8-bit magnitude, one result per input.
// cfg_we/cfg_wdata write the method bit: 0 exact floor root, 1 coarse
// approximation that drops low bits of the sum of squares first.
// Write the method only while no items are in flight.
// From input transfer to m_tvalid an item passes one stage for the
// squares, one for the sum, and four root stages of two digit steps each.
// One item per cycle when not stalled; every stage holds a valid bit.
// When the receiver stalls (m_tvalid high, m_tready low) the whole pipeline
// holds and s_tready drops, so nothing is lost or repeated.
// Synchronous reset clears all valid bits and sets the method to exact.
`timescale 1ns / 1ps
`default_nettype none

module vector_magnitude_int_sqrt_core
    import vmag_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // comp_x [7:0], comp_y [15:8]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // magnitude [7:0]
);

    localparam int unsigned NUM_ROOT_STAGES = 4;

    logic     method_reg;
    logic     en;
    vmag_sq_t pipe [NUM_ROOT_STAGES+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg <= METHOD_EXACT;
        end else if (cfg_we) begin
            method_reg <= cfg_wdata;
        end
    end

    // Advance all stages together unless the output is held.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    vmag_sumsq u_sumsq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_tvalid),
        .comp_x  (s_tdata[7:0]),
        .comp_y  (s_tdata[15:8]),
        .method  (method_reg),
        .sum_out (pipe[0])
    );

    for (genvar g = 0; g < NUM_ROOT_STAGES; g++) begin : g_root
        vmag_root_stage #(
            .TOP_BIT (7 - 2 * g)
        ) u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .d       (pipe[g]),
            .q       (pipe[g+1])
        );
    end

    assign m_tvalid = pipe[NUM_ROOT_STAGES].vld;
    assign m_tdata  = pipe[NUM_ROOT_STAGES].root[MAG_W:1];

    // Result is never beyond the largest possible length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata <= 8'd181))
        else $error("magnitude out of range");

    // Floor-root remainder bound: rem <= 2*root.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, pipe[NUM_ROOT_STAGES].rem} <=
                      {8'h00, pipe[NUM_ROOT_STAGES].root}))
        else $error("root remainder too large");

    // A stall freezes the middle of the pipeline.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(pipe[0]) && $stable(pipe[2].vld))
        else $error("pipeline moved during stall");

    // Root bit zero of the doubled root is never set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !pipe[NUM_ROOT_STAGES].root[0])
        else $error("doubled root has odd value");

endmodule

`default_nettype wire

// ----- rtl/vmag_sumsq.sv -----
// Two-stage front end: component squares, then sum of squares with optional coarsening.
`timescale 1ns / 1ps
`default_nettype none

module vmag_sumsq
    import vmag_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire logic                     in_vld,
    input  wire logic signed [COMP_W-1:0] comp_x,
    input  wire logic signed [COMP_W-1:0] comp_y,
    input  wire logic                     method,
    output vmag_sq_t                      sum_out
);

    logic [COMP_W:0]  abs_x;
    logic [COMP_W:0]  abs_y;
    logic             sq_vld_reg;
    logic [SUM_W-1:0] sq_x_reg;
    logic [SUM_W-1:0] sq_y_reg;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] sum_next;
    vmag_sq_t         sum_reg;

    assign abs_x = comp_x[COMP_W-1] ? ((COMP_W+1)'(0) - {comp_x[COMP_W-1], comp_x})
                                    : {1'b0, comp_x};
    assign abs_y = comp_y[COMP_W-1] ? ((COMP_W+1)'(0) - {comp_y[COMP_W-1], comp_y})
                                    : {1'b0, comp_y};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg <= 1'b0;
        end else if (en) begin
            sq_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_x_reg <= SUM_W'(abs_x) * SUM_W'(abs_x);
            sq_y_reg <= SUM_W'(abs_y) * SUM_W'(abs_y);
        end
    end

    assign sum = sq_x_reg + sq_y_reg;

    // Coarse mode drops low bits by magnitude range before the root.
    always_comb begin
        sum_next = sum;
        if (method == METHOD_COARSE) begin
            if (sum[SUM_W-1:11] != '0) begin
                sum_next = {sum[SUM_W-1:8], 8'h00};
            end else if (sum[SUM_W-1:7] != '0) begin
                sum_next = {sum[SUM_W-1:4], 4'h0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg.vld <= 1'b0;
        end else if (en) begin
            sum_reg.vld <= sq_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg.rem  <= sum_next;
            sum_reg.root <= '0;
        end
    end

    assign sum_out = sum_reg;

endmodule

`default_nettype wire

// ----- rtl/vmag_root_stage.sv -----
// One register stage of the root pipeline: two restoring digit steps.
`timescale 1ns / 1ps
`default_nettype none

module vmag_root_stage
    import vmag_pkg::*;
#(
    parameter int unsigned TOP_BIT = 7
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     en,
    input  wire vmag_sq_t d,
    output vmag_sq_t      q
);

    vmag_sq_t step_hi;
    vmag_sq_t stage_next;
    vmag_sq_t stage_reg;

    assign step_hi    = vmag_root_step(d, TOP_BIT);
    assign stage_next = vmag_root_step(step_hi, TOP_BIT - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.vld <= 1'b0;
        end else if (en) begin
            stage_reg.vld <= d.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg.rem  <= stage_next.rem;
            stage_reg.root <= stage_next.root;
        end
    end

    assign q = stage_reg;

endmodule

`default_nettype wire

// ----- verif/vector_magnitude_int_sqrt_core_tb.sv -----
// Self-checking testbench for the vector magnitude core: directed table, then random streams.
`timescale 1ns / 1ps

module vector_magnitude_int_sqrt_core_tb;
    import vmag_pkg::*;

    localparam int QUIET_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int SEG_ITEMS     = 275;
    localparam int NUM_SEGS      = 6;
    localparam int NUM_DIRECTED  = 24;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic              mode;
        logic signed [7:0] cx;
        logic signed [7:0] cy;
        bit                known;
        logic [7:0]        mag;
    } vec_case_t;

    // Known magnitudes only where they follow directly from the arithmetic.
    vec_case_t vec_cases [NUM_DIRECTED] = '{
        '{METHOD_EXACT,     0,    0, 1'b1,   0},
        '{METHOD_EXACT,  -128, -128, 1'b1, 181},
        '{METHOD_EXACT,   127,    0, 1'b1, 127},
        '{METHOD_EXACT,  -128,    0, 1'b1, 128},
        '{METHOD_EXACT,     0, -128, 1'b1, 128},
        '{METHOD_EXACT,     3,    4, 1'b1,   5},
        '{METHOD_EXACT,    -3,   -4, 1'b1,   5},
        '{METHOD_EXACT,   127,  127, 1'b0,   0},
        '{METHOD_EXACT,  -128,  127, 1'b0,   0},
        '{METHOD_EXACT,    11,    2, 1'b0,   0},
        '{METHOD_EXACT,     8,    8, 1'b0,   0},
        '{METHOD_EXACT,   -32,  -32, 1'b0,   0},
        '{METHOD_EXACT,    85,  -86, 1'b0,   0},
        '{METHOD_COARSE,    0,    0, 1'b1,   0},
        '{METHOD_COARSE, -128, -128, 1'b1, 181},
        '{METHOD_COARSE,  127,    0, 1'b1, 126},
        '{METHOD_COARSE, -128,    0, 1'b1, 128},
        '{METHOD_COARSE,    3,    4, 1'b1,   5},
        '{METHOD_COARSE,  127,  127, 1'b0,   0},
        '{METHOD_COARSE,   11,    2, 1'b0,   0},
        '{METHOD_COARSE,    8,    8, 1'b0,   0},
        '{METHOD_COARSE,   -32,  -32, 1'b0,   0},
        '{METHOD_COARSE,   45,   -8, 1'b0,   0},
        '{METHOD_COARSE,   31,   31, 1'b0,   0}
    };

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;    // comp_x [7:0], comp_y [15:8]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;           // magnitude [7:0]

    logic       cur_method = METHOD_EXACT;
    int         src_idle_pct = 27;
    int         snk_idle_pct = 45;
    logic [7:0] pending_mags [$];
    int         mag_errors = 0;

    vector_magnitude_int_sqrt_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Floor root of the sum of squares; coarse mode clears low sum bits first.
    function automatic logic [7:0] predict_magnitude(logic mode, logic signed [7:0] x,
                                                     logic signed [7:0] y);
        int xi;
        int yi;
        int sum_sq;
        int root;
        xi     = x;
        yi     = y;
        sum_sq = xi * xi + yi * yi;
        if (mode == METHOD_COARSE) begin
            if (sum_sq >= 2048)
                sum_sq = sum_sq & ~255;
            else if (sum_sq >= 128)
                sum_sq = sum_sq & ~15;
        end
        root = 0;
        while ((root + 1) * (root + 1) <= sum_sq)
            root++;
        return 8'(root);
    endfunction

    function automatic logic [7:0] rand_comp();
        case ($urandom_range(9, 0))
            0:       return $urandom_range(1, 0) ? 8'h80 : 8'h7F;
            1, 2:    return 8'($urandom_range(24, 0) - 12);
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_vector(input logic signed [7:0] x, input logic signed [7:0] y,
                               input bit known, input logic [7:0] known_mag);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        do @(posedge aclk); while (!s_tready);
        pending_mags.push_back(known ? known_mag : predict_magnitude(cur_method, x, y));
    endtask

    // Drain the pipeline, then write the method bit.
    task automatic set_method(input logic mode);
        s_tvalid <= 1'b0;
        while (pending_mags.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        cur_method  = mode;
    endtask

    // Result side: random backpressure and comparison against the oldest prediction.
    always @(posedge aclk) begin
        logic [7:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= snk_idle_pct);
            if (m_tvalid && m_tready) begin
                if (pending_mags.size() == 0) begin
                    mag_errors++;
                    if (mag_errors <= MAX_REPORTS)
                        $display("unexpected result: magnitude %0d", m_tdata);
                end else begin
                    want = pending_mags.pop_front();
                    if (m_tdata !== want) begin
                        mag_errors++;
                        if (mag_errors <= MAX_REPORTS)
                            $display("magnitude mismatch: expected %0d, got %0d", want, m_tdata);
                    end
                end
            end
        end
    end

    // Watchdog: stop when neither side transfers for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("vector_magnitude_int_sqrt_core_tb: errors");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_method(METHOD_EXACT);
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (vec_cases[i].mode != cur_method)
                set_method(vec_cases[i].mode);
            send_vector(vec_cases[i].cx, vec_cases[i].cy, vec_cases[i].known, vec_cases[i].mag);
        end

        // Two segments per backpressure profile, alternating the method.
        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            case (seg / 2)
                0: begin src_idle_pct = 27; snk_idle_pct = 45; end
                1: begin src_idle_pct = 45; snk_idle_pct = 27; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            set_method((seg % 2 == 0) ? METHOD_EXACT : METHOD_COARSE);
            for (int n = 0; n < SEG_ITEMS; n++)
                send_vector(rand_comp(), rand_comp(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (pending_mags.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_mags.size() != 0) begin
            $display("%0d results never arrived", pending_mags.size());
            mag_errors += pending_mags.size();
        end
        if (mag_errors == 0)
            $display("vector_magnitude_int_sqrt_core_tb: clean");
        else
            $display("vector_magnitude_int_sqrt_core_tb: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/vmag_pkg.sv
rtl/vmag_sumsq.sv
rtl/vmag_root_stage.sv
rtl/vector_magnitude_int_sqrt_core.sv
verif/vector_magnitude_int_sqrt_core_tb.sv
